FILE: design/brsa_pkg.sv
// shared constants, codes and types for the block recycling slot allocator
// no dependencies
package brsa_pkg;

  // fixed by the widths of the block id and slot fields
  localparam int NUM_BLOCKS = 32;
  localparam int BLK_W      = 5;
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_W     = 8;
  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 16;
  localparam int OFF_W      = 24;
  localparam int STAT_W     = 2;
  localparam int IU_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // default depth of the recycled block stack
  localparam int DEF_FREE_LIST_CAP = 20;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]  IPB_RESET  = CNT_W'(64);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITEMS_PER_BLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE       = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER_RELEASE = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;  // capture the request beat, start the stack read
    logic exec;   // evaluate and update the allocator state
    logic load;   // fill the output register
  } brsa_cmd_t;

endpackage

FILE: design/block_recycling_slot_allocator_top.sv
// top level of the block recycling slot allocator
// depends on brsa_pkg, brsa_ctrl, brsa_dp (and brsa_ram below it)
//
//  channel | handshake           | beat contents
//  --------+---------------------+------------------------------------------
//  in      | in_valid/in_ready   | kind, release_block
//  out     | out_valid/out_ready | block_id, slot_index, byte_offset,
//          |                     | status, blocks_in_use
//  cfg     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// each request passes through capture (stack top read from the ram),
// evaluate (one update of the bookkeeping state), then the offset multiply
// into the output register; a new request is taken only once the last is loaded
// synchronous active-low reset; all 32 release counts are flops cleared at
// once, so there is no clearing pass and a request can be taken right away
// a held result sits in the output register while the next request is
// captured and evaluated; only the output load waits for out_ready
module block_recycling_slot_allocator_top
  import brsa_pkg::*;
#(
  parameter int FREE_LIST_CAP = DEF_FREE_LIST_CAP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [BLK_W-1:0]      in_release_block,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BLK_W-1:0]      out_block_id,
  output logic [SLOT_W-1:0]     out_slot_index,
  output logic [OFF_W-1:0]      out_byte_offset,
  output logic [STAT_W-1:0]     out_status,
  output logic [IU_W-1:0]       out_blocks_in_use,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // commands from the sequencer to the datapath
  brsa_cmd_t cmd;

  // sequencer: capture, evaluate, load output
  brsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // bookkeeping state, recycled block stack and output register
  brsa_dp #(
    .FREE_LIST_CAP (FREE_LIST_CAP)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_kind),
    .in_release_block  (in_release_block),
    .out_block_id      (out_block_id),
    .out_slot_index    (out_slot_index),
    .out_byte_offset   (out_byte_offset),
    .out_status        (out_status),
    .out_blocks_in_use (out_blocks_in_use)
  );

endmodule

FILE: design/brsa_ram.sv
// generic single write port ram with registered read
// no dependencies
module brsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/brsa_ctrl.sv
// controller: sequences each request through capture, evaluate and output load
// depends on brsa_pkg
module brsa_ctrl
  import brsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output brsa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;

  assign in_ready = (state_r == S_IDLE);
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (load_ok) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/brsa_dp.sv
// datapath: configuration, block bookkeeping, recycled block stack and result
// depends on brsa_pkg and brsa_ram
module brsa_dp
  import brsa_pkg::*;
#(
  parameter int FREE_LIST_CAP = DEF_FREE_LIST_CAP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  brsa_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_kind,
  input  logic [BLK_W-1:0]      in_release_block,
  output logic [BLK_W-1:0]      out_block_id,
  output logic [SLOT_W-1:0]     out_slot_index,
  output logic [OFF_W-1:0]      out_byte_offset,
  output logic [STAT_W-1:0]     out_status,
  output logic [IU_W-1:0]       out_blocks_in_use
);

  localparam int FC_W = $clog2(FREE_LIST_CAP + 1);
  localparam int SA_W = (FREE_LIST_CAP > 1) ? $clog2(FREE_LIST_CAP) : 1;

  // configuration
  logic [CNT_W-1:0]  ipb_r;
  logic [SIZE_W-1:0] size_r;

  // allocator state
  logic [BLK_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] next_slot_r, next_slot_nxt;
  logic [CNT_W-1:0] rc_r [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] held_r;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic [IU_W-1:0]  iu_r, iu_nxt;

  // captured request
  logic             kind_r;
  logic [BLK_W-1:0] blk_r;

  // evaluated result, waiting for the offset multiply
  logic [BLK_W-1:0]  res_blk_r, res_blk_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;

  // output register
  logic [BLK_W-1:0]  o_blk_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [OFF_W-1:0]  o_off_r;
  logic [STAT_W-1:0] o_stat_r;
  logic [IU_W-1:0]   o_iu_r;

  // evaluation signals
  logic [CNT_W-1:0] n_eff;
  logic [BLK_W-1:0] rc_ra;
  logic [CNT_W-1:0] rc_rd;
  logic [CNT_W-1:0] rc_inc;
  logic             rc_we;
  logic [BLK_W-1:0] rc_wa;
  logic [CNT_W-1:0] rc_wd;
  logic             held_we;
  logic [BLK_W-1:0] held_wa;
  logic             held_wd;
  logic             found;
  logic [BLK_W-1:0] found_blk;
  logic [CNT_W-1:0] new_slot;
  logic             push;
  logic [FC_W-1:0]  fc_dec;
  logic [BLK_W-1:0] stack_rd;

  // lowest block still in the pool
  function automatic logic [BLK_W:0] find_free(input logic [NUM_BLOCKS-1:0] held);
    logic [BLK_W:0] res;
    res = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!held[i]) begin
        res = {1'b1, BLK_W'(i)};
      end
    end
    return res;
  endfunction

  assign fc_dec = fc_r - FC_W'(1);

  brsa_ram #(
    .WIDTH (BLK_W),
    .DEPTH (FREE_LIST_CAP),
    .AW    (SA_W)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (fc_r[SA_W-1:0]),
    .wdata (blk_r),
    .re    (cmd.latch),
    .raddr (fc_dec[SA_W-1:0]),
    .rdata (stack_rd)
  );

  // slot count clamped to 1..MAX_SLOTS
  always_comb begin
    n_eff = ipb_r;
    if (ipb_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (ipb_r > CNT_W'(MAX_SLOTS)) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end
  end

  assign rc_ra  = (kind_r == KIND_RELEASE) ? blk_r : cur_r;
  assign rc_rd  = rc_r[rc_ra];
  assign rc_inc = rc_rd + CNT_W'(1);
  assign {found, found_blk} = find_free(held_r);

  always_comb begin
    cur_nxt       = cur_r;
    next_slot_nxt = next_slot_r;
    fc_nxt        = fc_r;
    iu_nxt        = iu_r;
    rc_we         = 1'b0;
    rc_wa         = cur_r;
    rc_wd         = '0;
    held_we       = 1'b0;
    held_wa       = blk_r;
    held_wd       = 1'b0;
    push          = 1'b0;
    new_slot      = next_slot_r;
    res_blk_nxt   = blk_r;
    res_slot_nxt  = '0;
    res_stat_nxt  = ST_OK;
    if (kind_r == KIND_ALLOC) begin
      if (next_slot_r >= n_eff) begin
        new_slot = '0;
        if (rc_rd >= n_eff) begin
          // every slot came back, start the same block over
          rc_we = 1'b1;
          rc_wa = cur_r;
        end else if (fc_r == '0) begin
          if (found) begin
            held_we = 1'b1;
            held_wa = found_blk;
            held_wd = 1'b1;
            rc_we   = 1'b1;
            rc_wa   = found_blk;
            cur_nxt = found_blk;
            iu_nxt  = iu_r + IU_W'(1);
          end else begin
            res_stat_nxt = ST_NO_BLOCK;
          end
        end else begin
          // pop the most recently recycled block
          fc_nxt  = fc_dec;
          cur_nxt = stack_rd;
          rc_we   = 1'b1;
          rc_wa   = stack_rd;
          iu_nxt  = iu_r + IU_W'(1);
        end
      end
      if (res_stat_nxt == ST_OK) begin
        next_slot_nxt = new_slot + CNT_W'(1);
        res_blk_nxt   = cur_nxt;
        res_slot_nxt  = new_slot[SLOT_W-1:0];
      end else begin
        res_blk_nxt = '0;
      end
    end else begin
      if (!held_r[blk_r] || rc_rd >= n_eff) begin
        res_stat_nxt = ST_OVER_RELEASE;
      end else begin
        rc_we = 1'b1;
        rc_wa = blk_r;
        rc_wd = rc_inc;
        if (blk_r != cur_r && rc_inc >= n_eff) begin
          if (fc_r < FC_W'(FREE_LIST_CAP)) begin
            push   = 1'b1;
            fc_nxt = fc_r + FC_W'(1);
          end else begin
            held_we = 1'b1;
            held_wa = blk_r;
            held_wd = 1'b0;
          end
          if (iu_r != '0) begin
            iu_nxt = iu_r - IU_W'(1);
          end
        end
      end
    end
    if (!cmd.exec) begin
      push = 1'b0;
    end
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipb_r       <= IPB_RESET;
      size_r      <= SIZE_RESET;
      cur_r       <= '0;
      next_slot_r <= '0;
      held_r      <= NUM_BLOCKS'(1);
      fc_r        <= '0;
      iu_r        <= IU_W'(1);
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        rc_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ITEMS_PER_BLOCK: ipb_r  <= cfg_wdata[CNT_W-1:0];
          CFG_ITEM_SIZE:       size_r <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        cur_r       <= cur_nxt;
        next_slot_r <= next_slot_nxt;
        fc_r        <= fc_nxt;
        iu_r        <= iu_nxt;
        if (rc_we) begin
          rc_r[rc_wa] <= rc_wd;
        end
        if (held_we) begin
          held_r[held_wa] <= held_wd;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      blk_r  <= in_release_block;
    end
    if (cmd.exec) begin
      res_blk_r  <= res_blk_nxt;
      res_slot_r <= res_slot_nxt;
      res_stat_r <= res_stat_nxt;
    end
    if (cmd.load) begin
      o_blk_r  <= res_blk_r;
      o_slot_r <= res_slot_r;
      o_off_r  <= OFF_W'(res_slot_r) * OFF_W'(size_r);
      o_stat_r <= res_stat_r;
      o_iu_r   <= iu_r;
    end
  end

  assign out_block_id      = o_blk_r;
  assign out_slot_index    = o_slot_r;
  assign out_byte_offset   = o_off_r;
  assign out_status        = o_stat_r;
  assign out_blocks_in_use = o_iu_r;

endmodule
